[rtl/abpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package abpc_pkg;

  // Default frame limits (line buffer depth and row counter range)
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_ADDR_W     = $clog2(DEF_MAX_WIDTH);

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int ALPHA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0]   WIDTH_RESET     = 11'd1024;
  localparam logic [CFG_W-1:0]   HEIGHT_RESET    = 11'd1024;
  localparam logic [ALPHA_W-1:0] THRESHOLD_RESET = 8'd100;

  localparam int COL_W = 10;
  localparam int ROW_W = 10;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  typedef enum logic [1:0] {
    CLASS_EMPTY    = 2'd0,
    CLASS_BORDER   = 2'd1,
    CLASS_INTERIOR = 2'd2
  } pixel_class_t;

  typedef struct packed {
    logic               kind;
    logic [ALPHA_W-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    pixel_class_t     pixel_class;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } out_item_t;

  // Per-beat control bits handed from the position tracker to the classifier
  typedef struct packed {
    logic has_result;
    logic cur_t;
    logic first_col;
    logic last_col;
    logic frame_end;
    logic ok_center;
    logic ok_right;
    logic ok_left;
  } desc_flags_t;

endpackage

`default_nettype wire

[rtl/abpc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module abpc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = abpc_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[rtl/abpc_pos.sv]
`timescale 1ns / 1ps
`default_nettype none

module abpc_pos #(
  parameter int MAX_WIDTH  = abpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = abpc_pkg::DEF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [abpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [abpc_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                accept,
  input  wire abpc_pkg::in_item_t                  item,
  output abpc_pkg::desc_flags_t                    flags,
  output logic      [AW-1:0]                       col,
  output logic      [abpc_pkg::ROW_W-1:0]          row,
  output logic      [AW-1:0]                       addr_right,
  output logic      [AW-1:0]                       addr_left
);

  import abpc_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CHW = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [ALPHA_W-1:0] alpha_threshold;

  logic [AW-1:0] col_count;
  logic [HW-1:0] row_count;
  // columns 0..fill-1 have been written since the buffers were last cleared
  logic [WW-1:0] fill;

  logic [CWW-1:0] w_raw;
  logic [CHW-1:0] h_raw;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [WW-1:0]  col_inc;
  logic           flush;

  always_comb begin
    w_raw = CWW'(image_width);
    h_raw = CHW'(image_height);

    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > CWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_raw);
    end

    if (h_raw == '0) begin
      h_eff = HW'(1);
    end else if (h_raw > CHW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_raw);
    end

    // a width shrunk mid-row pins the column to the new last one
    col     = (WW'(col_count) >= w_eff) ? AW'(w_eff - WW'(1)) : col_count;
    col_inc = WW'(col) + WW'(1);
    flush   = (row_count >= h_eff);

    flags.has_result = (row_count != '0);
    flags.cur_t      = flush || (item.kind == KIND_PAD) || (item.alpha < alpha_threshold);
    flags.first_col  = (col == '0);
    flags.last_col   = (col_inc >= w_eff);
    flags.frame_end  = flush && (col_inc >= w_eff);
    flags.ok_center  = (col_inc <= fill);
    flags.ok_right   = (col_inc < fill);
    flags.ok_left    = (WW'(col) <= fill);

    row        = ROW_W'(row_count - HW'(1));
    addr_right = col + AW'(1);
    addr_left  = col - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_RESET;
      image_height    <= HEIGHT_RESET;
      alpha_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:     image_width     <= cfg_data;
        CFG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        CFG_ALPHA_THRESHOLD: alpha_threshold <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      fill      <= '0;
    end else if (accept) begin
      if (flags.last_col) begin
        col_count <= '0;
        row_count <= flush ? '0 : row_count + HW'(1);
      end else begin
        col_count <= AW'(col_inc);
      end

      if (flags.frame_end) begin
        fill <= '0;
      end else if (col_inc > fill) begin
        fill <= col_inc;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/abpc_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module abpc_core #(
  parameter int AW = abpc_pkg::DEF_ADDR_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire abpc_pkg::desc_flags_t         flags,
  input  wire logic [AW-1:0]                 col,
  input  wire logic [abpc_pkg::ROW_W-1:0]    row,
  input  wire logic                          prev_c,
  input  wire logic                          prev_r,
  input  wire logic                          older_c,
  input  wire logic                          older_l,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output abpc_pkg::out_item_t                out_data,
  output logic                               wr_en,
  output logic      [AW-1:0]                 wr_addr,
  output logic                               wr_prev,
  output logic                               wr_older
);

  import abpc_pkg::*;

  logic                s1_valid;
  desc_flags_t         s1_flags;
  logic [AW-1:0]       s1_col;
  logic [ROW_W-1:0]    s1_row;

  // write of the beat that left stage 1 as this one was read; the RAM
  // returned pre-write data for that address
  logic                fwd_en;
  logic [AW-1:0]       fwd_col;
  logic                fwd_prev;
  logic                fwd_older;

  logic         hit_c;
  logic         hit_r;
  logic         hit_l;
  logic         center;
  logic         up;
  logic         right;
  logic         left;
  logic         advance;
  pixel_class_t cls;

  always_comb begin
    hit_c = fwd_en && (fwd_col == s1_col);
    hit_r = fwd_en && (fwd_col == s1_col + AW'(1));
    hit_l = fwd_en && (fwd_col == s1_col - AW'(1));

    // entries not written since the last clear read as transparent
    if (hit_c) begin
      center = fwd_prev;
      up     = fwd_older;
    end else if (s1_flags.ok_center) begin
      center = prev_c;
      up     = older_c;
    end else begin
      center = 1'b1;
      up     = 1'b1;
    end

    if (s1_flags.last_col) begin
      right = 1'b1;
    end else if (hit_r) begin
      right = fwd_prev;
    end else if (s1_flags.ok_right) begin
      right = prev_r;
    end else begin
      right = 1'b1;
    end

    if (s1_flags.first_col) begin
      left = 1'b1;
    end else if (hit_l) begin
      left = fwd_older;
    end else if (s1_flags.ok_left) begin
      left = older_l;
    end else begin
      left = 1'b1;
    end

    if (center) begin
      cls = CLASS_EMPTY;
    end else if (up || left || right || s1_flags.cur_t) begin
      cls = CLASS_BORDER;
    end else begin
      cls = CLASS_INTERIOR;
    end

    advance  = s1_valid && (!s1_flags.has_result || !out_valid || out_ready);
    free     = !s1_valid || advance;

    wr_en    = advance;
    wr_addr  = s1_col;
    wr_prev  = s1_flags.cur_t;
    wr_older = center;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_en   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        // a frame-end beat clears the buffers, so nothing carries over
        fwd_en   <= advance && !s1_flags.frame_end;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags  <= flags;
      s1_col    <= col;
      s1_row    <= row;
      fwd_col   <= s1_col;
      fwd_prev  <= s1_flags.cur_t;
      fwd_older <= center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_flags.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_flags.has_result) begin
      out_data.pixel_class <= cls;
      out_data.col         <= COL_W'(s1_col);
      out_data.row         <= s1_row;
      out_data.frame_end   <= s1_flags.frame_end;
    end
  end

endmodule

`default_nettype wire

[rtl/alpha_boundary_pixel_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none

// Classifies a raster-order alpha stream as empty, border or interior pixels
// (4-neighbour boundary test against alpha_threshold; outside the image is
// transparent). Results trail the input by one row: row zero gives no beats,
// and after each frame the host sends image_width pad beats to flush the last
// row, whose final result carries frame_end. One pixel is taken every clock;
// pixels wait in stage 1, results in the output register; out_ready low
// stalls the input only once the output register and the stage behind it are
// both full. Two line buffers of MAX_WIDTH bits, each one RAM with one write
// and two registered reads per clock, hold the transparency of the last two
// rows; a fill count marks what was written this frame, so reset and frame
// end need no clearing pass. Write configuration only while no pixel is in
// flight; width and height of zero act as one and values above the maximum
// act as the maximum.

module alpha_boundary_pixel_classifier #(
  parameter int MAX_WIDTH  = abpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = abpc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire abpc_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output abpc_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [abpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abpc_pkg::CFG_W-1:0]      cfg_data
);

  import abpc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic             accept;
  desc_flags_t      flags;
  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [AW-1:0]    addr_right;
  logic [AW-1:0]    addr_left;
  logic             prev_c;
  logic             prev_r;
  logic             older_c;
  logic             older_l;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             wr_prev;
  logic             wr_older;

  assign accept = in_valid && in_ready;

  abpc_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .item       (in_data),
    .flags      (flags),
    .col        (col),
    .row        (row),
    .addr_right (addr_right),
    .addr_left  (addr_left)
  );

  // transparency of the row above the one being classified
  abpc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_prev_row (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_prev),
    .re      (accept),
    .raddr_a (col),
    .raddr_b (addr_right),
    .rdata_a (prev_c),
    .rdata_b (prev_r)
  );

  // transparency of the row before that
  abpc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_older_row (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_older),
    .re      (accept),
    .raddr_a (col),
    .raddr_b (addr_left),
    .rdata_a (older_c),
    .rdata_b (older_l)
  );

  abpc_core #(
    .AW (AW)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .flags     (flags),
    .col       (col),
    .row       (row),
    .prev_c    (prev_c),
    .prev_r    (prev_r),
    .older_c   (older_c),
    .older_l   (older_l),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_prev   (wr_prev),
    .wr_older  (wr_older)
  );

endmodule

`default_nettype wire

[test/abpc_checker.sv]
`timescale 1ns / 1ps

module abpc_checker
  import abpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errs,
  output int                   pending,
  output logic                 at_frame_start
);

  localparam int unsigned LINE_W   = DEF_MAX_WIDTH;
  localparam int unsigned MAX_ROWS = DEF_MAX_HEIGHT;
  localparam int          MAX_REPORTS = 40;

  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [ALPHA_W-1:0] thr_reg;

  // transparency of the last row written and the row above it
  bit [LINE_W-1:0]    prev_t;
  bit [LINE_W-1:0]    older_t;
  int unsigned        col_pos;
  int unsigned        row_pos;

  out_item_t          class_q[$];
  int                 err_count = 0;
  int                 q_depth = 0;
  logic               frame_start_q = 1'b1;

  assign errs           = err_count;
  assign pending        = q_depth;
  assign at_frame_start = frame_start_q;

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS)
      $display("%0t ns checker: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic take_pixel(input in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic        flush;
    logic        last;
    logic        cur_t;
    logic        up;
    logic        left;
    logic        right;
    out_item_t   exp_item;
    w = eff_dim(width_reg, LINE_W);
    h = eff_dim(height_reg, MAX_ROWS);
    // a width shrunk mid-row closes the row at the new last column
    c = (col_pos >= w) ? w - 1 : col_pos;
    flush = (row_pos >= h);
    last  = (c + 1 >= w);
    cur_t = flush || (it.kind == KIND_PAD) || (it.alpha < thr_reg);
    if (row_pos >= 1) begin
      up    = older_t[c];
      // left neighbor already moved to older_t when its own beat came in
      left  = (c == 0) ? 1'b1 : older_t[c-1];
      right = last ? 1'b1 : prev_t[c+1];
      if (prev_t[c])
        exp_item.pixel_class = CLASS_EMPTY;
      else if (up || left || right || cur_t)
        exp_item.pixel_class = CLASS_BORDER;
      else
        exp_item.pixel_class = CLASS_INTERIOR;
      exp_item.col       = COL_W'(c);
      exp_item.row       = ROW_W'(row_pos - 1);
      exp_item.frame_end = flush && last;
      class_q = {class_q, exp_item};
    end
    older_t[c] = prev_t[c];
    prev_t[c]  = cur_t;
    if (last) begin
      col_pos = 0;
      if (flush) begin
        row_pos = 0;
        prev_t  = '1;
        older_t = '1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_beat();
    out_item_t want;
    if (class_q.size() == 0) begin
      report("result beat with nothing pending, col", int'(out_data.col), -1);
    end else begin
      want = class_q.pop_front();
      if (out_data.pixel_class !== want.pixel_class)
        report("pixel_class", int'(out_data.pixel_class), int'(want.pixel_class));
      if (out_data.col !== want.col)
        report("col", int'(out_data.col), int'(want.col));
      if (out_data.row !== want.row)
        report("row", int'(out_data.row), int'(want.row));
      if (out_data.frame_end !== want.frame_end)
        report("frame_end", int'(out_data.frame_end), int'(want.frame_end));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      thr_reg    = THRESHOLD_RESET;
      prev_t     = '1;
      older_t    = '1;
      col_pos    = 0;
      row_pos    = 0;
      class_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:     width_reg = cfg_data;
          CFG_IMAGE_HEIGHT:    height_reg = cfg_data;
          CFG_ALPHA_THRESHOLD: thr_reg = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) take_pixel(in_data);
    end
    q_depth       <= class_q.size();
    frame_start_q <= (col_pos == 0) && (row_pos == 0);
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import abpc_pkg::*;

  localparam int IDLE_PCT       = 28;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 800;
  localparam int DRAIN_SLACK    = 6;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int                   errs;
  int                   pending;
  logic                 at_frame_start;

  logic                 calm;
  logic                 squeeze;
  logic [CFG_W-1:0]     cur_w;
  logic [CFG_W-1:0]     cur_h;
  logic [ALPHA_W-1:0]   cur_thr;
  int unsigned          items_sent;
  int                   stall_cycles;

  alpha_boundary_pixel_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  abpc_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errs           (errs),
    .pending        (pending),
    .at_frame_start (at_frame_start)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: random stalls, one long hold-off when asked
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        hold_left = HOLD_CYCLES;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL alpha_boundary_pixel_classifier");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic in_item_t pix(input logic kind, input logic [ALPHA_W-1:0] alpha);
    in_item_t it;
    it.kind  = kind;
    it.alpha = alpha;
    return it;
  endfunction

  function automatic in_item_t image_pixel(input int opaque_pct);
    in_item_t it;
    int       roll;
    roll    = $urandom_range(99, 0);
    it.kind = KIND_PIXEL;
    if (roll < 4) begin
      it.kind  = KIND_PAD;
      it.alpha = ALPHA_W'($urandom);
    end else if (roll < 12) begin
      // right at the threshold or one below it
      it.alpha = (cur_thr != 0 && roll[0]) ? cur_thr - 1'b1 : cur_thr;
    end else if (cur_thr == 0 || $urandom_range(99, 0) < opaque_pct) begin
      it.alpha = ALPHA_W'($urandom_range(255, int'(cur_thr)));
    end else begin
      it.alpha = ALPHA_W'($urandom_range(int'(cur_thr) - 1, 0));
    end
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind  = 1'($urandom_range(1, 0));
    it.alpha = ALPHA_W'($urandom);
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [ALPHA_W-1:0] thr, input logic [2:0] mask);
    if (mask[0]) begin
      write_reg(CFG_IMAGE_WIDTH, w);
      cur_w = w;
    end
    if (mask[1]) begin
      write_reg(CFG_IMAGE_HEIGHT, h);
      cur_h = h;
    end
    if (mask[2]) begin
      write_reg(CFG_ALPHA_THRESHOLD, CFG_W'(thr));
      cur_thr = thr;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // wait out every pending result plus the pipeline, so registers can be touched
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // one beat at a time until the position is back at the start of a frame
  task automatic finish_frame();
    while (!at_frame_start) begin
      send_item(noise_item());
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_frame(input int opaque_pct, input bit broken);
    int unsigned w;
    int unsigned n;
    int unsigned cut;
    int unsigned k;
    w   = eff_dim(cur_w, DEF_MAX_WIDTH);
    n   = w * (eff_dim(cur_h, DEF_MAX_HEIGHT) + 1);
    cut = broken ? $urandom_range(n - 1, 1) : n;
    // last w beats are the flush row: content there must not matter
    for (k = 0; k < cut; k++)
      send_item((k + w < n) ? image_pixel(opaque_pct) : noise_item());
    drain();
    if (broken) begin
      if ($urandom_range(1, 0))
        program_regs(CFG_W'($urandom_range(12, 0)), cur_h, cur_thr, 3'b001);
      else
        program_regs(cur_w, CFG_W'($urandom_range(12, 0)), cur_thr, 3'b010);
      finish_frame();
      drain();
    end
  endtask

  initial begin
    int unsigned        random_start;
    int                 roll;
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    logic [ALPHA_W-1:0] t;
    logic [2:0]         mask;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    calm      <= 1'b0;
    squeeze   <= 1'b0;
    cur_w      = WIDTH_RESET;
    cur_h      = HEIGHT_RESET;
    cur_thr    = THRESHOLD_RESET;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3 opaque block: (1,1) interior, pad at (2,2), threshold edge in row 0
    program_regs(11'd3, 11'd3, 8'd100, 3'b111);
    send_item(pix(KIND_PIXEL, 8'd100));
    send_item(pix(KIND_PIXEL, 8'd255));
    send_item(pix(KIND_PIXEL, 8'd99));
    repeat (5) send_item(pix(KIND_PIXEL, 8'd255));
    send_item(pix(KIND_PAD, 8'd255));
    send_item(pix(KIND_PIXEL, 8'd255));
    send_item(pix(KIND_PIXEL, 8'd0));
    send_item(pix(KIND_PAD, 8'd0));
    drain();

    program_regs(11'd1, 11'd2, 8'd255, 3'b111);
    send_item(pix(KIND_PIXEL, 8'd254));
    send_item(pix(KIND_PIXEL, 8'd255));
    send_item(pix(KIND_PIXEL, 8'd255));
    drain();

    program_regs(11'd2, 11'd1, 8'd0, 3'b111);
    send_item(pix(KIND_PIXEL, 8'd0));
    send_item(pix(KIND_PIXEL, 8'd0));
    send_item(pix(KIND_PAD, 8'd0));
    send_item(pix(KIND_PAD, 8'd255));
    drain();

    // zero sizes behave as one
    program_regs(11'd0, 11'd0, 8'd100, 3'b111);
    send_item(pix(KIND_PIXEL, 8'd200));
    send_item(pix(KIND_PIXEL, 8'd200));
    drain();

    program_regs(11'd4, 11'd3, 8'd100, 3'b111);
    repeat (6) send_item(pix(KIND_PIXEL, 8'd255));
    drain();
    // col 2 is now past the end, so the next beat closes row 1
    program_regs(11'd2, cur_h, cur_thr, 3'b001);
    send_item(pix(KIND_PIXEL, 8'd255));
    drain();
    // row 2 now lies beyond the height and turns into the flush row
    program_regs(cur_w, 11'd1, cur_thr, 3'b010);
    finish_frame();
    drain();

    // oversized sizes clamp: a long stretch of row 0, then both pulled in
    // so the frame closes early
    program_regs(11'd2047, 11'd2047, ALPHA_W'($urandom), 3'b111);
    repeat (48) send_item(image_pixel(70));
    drain();
    program_regs(11'd3, 11'd2, cur_thr, 3'b011);
    finish_frame();
    drain();

    // long output hold-off while the sender never pauses
    calm    <= 1'b1;
    squeeze <= 1'b1;
    program_regs(11'd24, 11'd8, cur_thr, 3'b011);
    run_frame(80, 1'b0);
    calm <= 1'b0;

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      roll = $urandom_range(99, 0);
      if (roll < 4)
        w = '0;
      else if (roll < 88)
        w = CFG_W'($urandom_range(20, 1));
      else
        w = CFG_W'($urandom_range(64, 21));
      h = ($urandom_range(99, 0) < 4) ? '0 : CFG_W'($urandom_range(10, 1));
      roll = $urandom_range(99, 0);
      if (roll < 10)
        t = '0;
      else if (roll < 20)
        t = '1;
      else
        t = ALPHA_W'($urandom);
      mask = (items_sent == random_start) ? 3'b111 : 3'($urandom_range(7, 1));
      program_regs(w, h, t, mask);
      run_frame($urandom_range(100, 30), $urandom_range(99, 0) < 12);
    end

    drain();
    repeat (16) @(posedge clk);
    if (errs == 0 && pending == 0)
      $display("PASS alpha_boundary_pixel_classifier");
    else
      $display("FAIL alpha_boundary_pixel_classifier");
    $finish;
  end

endmodule

[alpha_boundary_pixel_classifier.f]
rtl/abpc_pkg.sv
rtl/abpc_ram.sv
rtl/abpc_pos.sv
rtl/abpc_core.sv
rtl/alpha_boundary_pixel_classifier.sv
test/abpc_checker.sv
test/tb.sv
